/* src/rhcb_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// rhcb_pkg
// Shared types, constants and elaboration-time helpers for the rolling hash
// chunk boundary block.
// ----------------------------------------------------------------------------
package rhcb_pkg;

  // Fixed field widths of the interface.
  localparam int BYTE_W = 8;
  localparam int POS_W  = 32;
  localparam int SKIP_W = 12;

  // Shift applied to the xor hash before each new byte is folded in.
  localparam int HASH_SHIFT = 5;

  // Width of the divisibility test: one bit above the hash so that hash + 1
  // never wraps.
  localparam int TEST_W = POS_W + 1;

  // Result buffer geometry (power-of-two depth so the pointers wrap freely).
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);

  // Configuration register indexes.
  typedef enum logic [0:0] {
    REG_SKIP_BYTES   = 1'b0,
    REG_NETWORK_MODE = 1'b1
  } cfg_reg_t;

  // One chunk result word.
  typedef struct packed {
    logic [POS_W-1:0] chunk_start;
    logic [POS_W-1:0] chunk_end;
    logic             tail_chunk;
    logic             chunk_empty;
    logic             last_of_run;
  } result_t;

  // Number of trailing zero bits of a positive constant.
  function automatic int trailing_zeros(int value);
    int   n;
    logic done;
    n    = 0;
    done = 1'b0;
    for (int i = 0; i < 32; i++) begin
      if (!done && (value[i] == 1'b0)) begin
        n++;
      end else begin
        done = 1'b1;
      end
    end
    return n;
  endfunction

  // Multiplicative inverse of an odd constant modulo 2^TEST_W (Newton steps,
  // each one doubles the number of correct low bits).
  function automatic logic [TEST_W-1:0] odd_inverse(logic [TEST_W-1:0] odd);
    logic [TEST_W-1:0] inv;
    inv = odd;
    for (int i = 0; i < 6; i++) begin
      inv = inv * (TEST_W'(2) - odd * inv);
    end
    return inv;
  endfunction

endpackage
`default_nettype wire

/* src/rhcb_div_check.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// rhcb_div_check
// Tests whether hash mod BLOCK_DIVISOR equals BLOCK_DIVISOR-1, i.e. whether
// hash + 1 is a multiple of the divisor, with one constant multiplication.
// ----------------------------------------------------------------------------
module rhcb_div_check
  import rhcb_pkg::*;
#(
  parameter int BLOCK_DIVISOR = 320
) (
  input  wire logic [POS_W-1:0] hash_value,
  output logic                  hit
);

  // Divisor split into a power of two and an odd factor.
  localparam int TZ = trailing_zeros(BLOCK_DIVISOR);
  localparam int ODD_PART = BLOCK_DIVISOR >> TZ;
  localparam logic [TEST_W-1:0] ODD_INV = odd_inverse(TEST_W'(ODD_PART));
  localparam logic [TEST_W-1:0] ODD_LIMIT = TEST_W'(64'h1_FFFF_FFFF / ODD_PART);
  localparam logic [TEST_W-1:0] LOW_MASK = TEST_W'((64'd1 << TZ) - 64'd1);

  logic [TEST_W-1:0] plus_one;
  logic [TEST_W-1:0] odd_quot;
  logic [TEST_W-1:0] inv_prod;

  // The power-of-two factor must divide the low bits; the odd factor divides
  // the rest exactly when the product with its inverse stays under the limit.
  assign plus_one = {1'b0, hash_value} + TEST_W'(1);
  assign odd_quot = plus_one >> TZ;
  assign inv_prod = odd_quot * ODD_INV;
  assign hit      = ((plus_one & LOW_MASK) == '0) && (inv_prod <= ODD_LIMIT);

endmodule
`default_nettype wire

/* src/rhcb_chunker.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// rhcb_chunker
// Rolling hash state, boundary detection, skip handling and chunk bookkeeping.
// Consumes one registered byte per advance and forms up to two results.
// ----------------------------------------------------------------------------
module rhcb_chunker
  import rhcb_pkg::*;
#(
  parameter int WINDOW_LEN    = 7,
  parameter int BLOCK_DIVISOR = 320
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              cfg_write,
  input  wire logic [0:0]        cfg_index,
  input  wire logic [SKIP_W-1:0] cfg_data,
  input  wire logic              advance,
  input  wire logic [BYTE_W-1:0] data_byte,
  input  wire logic [POS_W-1:0]  stream_length,
  output result_t                res0,
  output result_t                res1,
  output logic [1:0]             res_count
);

  localparam logic [POS_W-1:0] WEIGHT = POS_W'(WINDOW_LEN);

  // Configuration registers.
  logic [SKIP_W-1:0] skip_bytes;
  logic              network_mode;

  // Stream state.
  logic [BYTE_W-1:0] window_bytes [WINDOW_LEN];
  logic [POS_W-1:0]  window_sum;
  logic [POS_W-1:0]  weighted_sum;
  logic [POS_W-1:0]  shift_xor_hash;
  logic [POS_W-1:0]  byte_position;
  logic [POS_W-1:0]  chunk_begin;
  logic [SKIP_W-1:0] skip_left;
  logic              first_pending;

  logic [POS_W-1:0]  len_eff;
  logic [POS_W-1:0]  last_pos;
  logic              final_byte;
  logic              skipping;
  logic [POS_W-1:0]  byte_ext;
  logic [POS_W-1:0]  window_sum_next;
  logic [POS_W-1:0]  weighted_sum_next;
  logic [POS_W-1:0]  shift_xor_hash_next;
  logic [POS_W-1:0]  hash_value;
  logic              div_hit;
  logic              boundary;
  logic              swallow;
  logic              emit_boundary;
  logic              emit_tail;
  logic              skip_fits;
  logic [POS_W-1:0]  pos_plus_one;
  logic [POS_W-1:0]  begin_after;
  result_t           boundary_res;
  result_t           tail_res;

  // Stream length and end-of-stream detection (a zero length counts as one).
  assign len_eff    = (stream_length == '0) ? POS_W'(1) : stream_length;
  assign last_pos   = len_eff - POS_W'(1);
  assign final_byte = (byte_position >= last_pos);
  assign skipping   = (skip_left != '0);

  // Rolling hash update; the oldest byte sits at the far end of the window.
  assign byte_ext            = {{(POS_W-BYTE_W){1'b0}}, data_byte};
  assign window_sum_next     = window_sum + byte_ext
                               - {{(POS_W-BYTE_W){1'b0}}, window_bytes[WINDOW_LEN-1]};
  assign weighted_sum_next   = weighted_sum - window_sum + WEIGHT * byte_ext;
  assign shift_xor_hash_next = (shift_xor_hash << HASH_SHIFT) ^ byte_ext;
  assign hash_value          = window_sum_next + weighted_sum_next + shift_xor_hash_next;

  rhcb_div_check #(
    .BLOCK_DIVISOR(BLOCK_DIVISOR)
  ) u_div_check (
    .hash_value(hash_value),
    .hit       (div_hit)
  );

  // Boundary decision and what follows from it.
  assign boundary      = !skipping && div_hit;
  assign swallow       = network_mode && first_pending;
  assign emit_boundary = boundary && !swallow;
  assign emit_tail     = final_byte && !network_mode;
  assign pos_plus_one  = byte_position + POS_W'(1);
  assign begin_after   = boundary ? pos_plus_one : chunk_begin;
  assign skip_fits     = ({1'b0, byte_position} + {{(POS_W+1-SKIP_W){1'b0}}, skip_bytes})
                         < {1'b0, len_eff};

  // Result words: the boundary chunk comes before the tail chunk.
  always_comb begin
    boundary_res.chunk_start = chunk_begin;
    boundary_res.chunk_end   = byte_position;
    boundary_res.tail_chunk  = 1'b0;
    boundary_res.chunk_empty = (chunk_begin > byte_position);
    boundary_res.last_of_run = !emit_tail;

    tail_res.chunk_start = begin_after;
    tail_res.chunk_end   = last_pos;
    tail_res.tail_chunk  = 1'b1;
    tail_res.chunk_empty = (begin_after > last_pos);
    tail_res.last_of_run = 1'b1;

    res0      = emit_boundary ? boundary_res : tail_res;
    res1      = tail_res;
    res_count = {1'b0, emit_boundary} + {1'b0, emit_tail};
  end

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      skip_bytes   <= SKIP_W'(64);
      network_mode <= 1'b0;
    end else if (cfg_write) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_SKIP_BYTES:   skip_bytes   <= cfg_data;
        REG_NETWORK_MODE: network_mode <= cfg_data[0];
        default:          ;
      endcase
    end
  end

  // State update per consumed byte; the final byte clears everything.
  always_ff @(posedge clk) begin
    if (rst || (advance && final_byte)) begin
      for (int i = 0; i < WINDOW_LEN; i++) begin
        window_bytes[i] <= '0;
      end
      window_sum     <= '0;
      weighted_sum   <= '0;
      shift_xor_hash <= '0;
      byte_position  <= '0;
      chunk_begin    <= '0;
      skip_left      <= '0;
      first_pending  <= 1'b1;
    end else if (advance) begin
      byte_position <= pos_plus_one;
      if (skipping) begin
        skip_left <= skip_left - SKIP_W'(1);
      end else begin
        window_bytes[0] <= data_byte;
        for (int i = 1; i < WINDOW_LEN; i++) begin
          window_bytes[i] <= window_bytes[i-1];
        end
        window_sum     <= window_sum_next;
        weighted_sum   <= weighted_sum_next;
        shift_xor_hash <= shift_xor_hash_next;
        if (boundary) begin
          if (swallow) begin
            first_pending <= 1'b0;
          end
          chunk_begin <= pos_plus_one;
          if (skip_fits) begin
            skip_left <= skip_bytes;
          end
        end
      end
    end
  end

  // The end of a stream returns the position and skip state to their start.
  a_final_clears: assert property (@(posedge clk) disable iff (rst)
    (advance && final_byte) |=> (byte_position == '0 && skip_left == '0 && first_pending))
    else $error("state not cleared after final byte");

  // Two results only come from the final byte of a stream.
  a_two_only_final: assert property (@(posedge clk) disable iff (rst)
    (advance && res_count == 2'd2) |-> final_byte)
    else $error("two results from a non-final byte");

  // A skipped byte counts the skip down by exactly one.
  a_skip_countdown: assert property (@(posedge clk) disable iff (rst)
    (advance && skipping && !final_byte) |=> (skip_left == $past(skip_left) - SKIP_W'(1)))
    else $error("skip counter did not step down");

endmodule
`default_nettype wire

/* src/rhcb_result_fifo.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// rhcb_result_fifo
// Small result buffer: takes up to two words per cycle, hands out one per
// cycle while out_ready is high, and reports room for a full pair.
// ----------------------------------------------------------------------------
module rhcb_result_fifo
  import rhcb_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic [1:0] push_count,
  input  wire result_t push0,
  input  wire result_t push1,
  output logic         space,
  input  wire logic    out_ready,
  output logic         out_valid,
  output result_t      head
);

  localparam logic [FIFO_PTR_W:0] SPACE_LIMIT = (FIFO_PTR_W+1)'(FIFO_DEPTH - 2);
  localparam logic [FIFO_PTR_W:0] FULL_COUNT  = (FIFO_PTR_W+1)'(FIFO_DEPTH);

  result_t                entries [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0]  wr_ptr;
  logic [FIFO_PTR_W-1:0]  rd_ptr;
  logic [FIFO_PTR_W:0]    count;
  logic [FIFO_PTR_W:0]    count_next;
  logic                   pop_fire;
  logic [FIFO_PTR_W-1:0]  wr_ptr_second;

  // Handshake and occupancy.
  assign out_valid     = (count != '0);
  assign head          = entries[rd_ptr];
  assign pop_fire      = out_valid && out_ready;
  assign space         = (count <= SPACE_LIMIT);
  assign wr_ptr_second = wr_ptr + FIFO_PTR_W'(1);
  assign count_next    = count + {{(FIFO_PTR_W-1){1'b0}}, push_count}
                         - {{FIFO_PTR_W{1'b0}}, pop_fire};

  // Pointers and count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + push_count[FIFO_PTR_W-1:0];
      if (pop_fire) begin
        rd_ptr <= rd_ptr + FIFO_PTR_W'(1);
      end
      count <= count_next;
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push_count != 2'd0) begin
      entries[wr_ptr] <= push0;
    end
    if (push_count == 2'd2) begin
      entries[wr_ptr_second] <= push1;
    end
  end

  // Occupancy never passes the depth.
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    count <= FULL_COUNT)
    else $error("result buffer overflow");

  // Words are only written when room for a pair was reported.
  a_push_with_space: assert property (@(posedge clk) disable iff (rst)
    (push_count != 2'd0) |-> space)
    else $error("push without room");

  // A lone read drops the occupancy by one.
  a_pop_count: assert property (@(posedge clk) disable iff (rst)
    (pop_fire && push_count == 2'd0) |=> (count == $past(count) - (FIFO_PTR_W+1)'(1)))
    else $error("occupancy wrong after read");

endmodule
`default_nettype wire

/* src/rolling_hash_chunk_boundaries.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// rolling_hash_chunk_boundaries
// Content-defined chunking of a byte stream with a windowed rolling hash.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries one byte per word together with
//   the total stream length. Output channel (out_valid/out_ready) carries one
//   chunk per word: start, inclusive end, tail and empty marks, and
//   last_of_run on the final chunk caused by a given byte. A byte causes zero,
//   one or two chunks (a boundary on the final byte yields the boundary chunk
//   followed by an empty tail chunk).
//   The configuration port (cfg_write/cfg_index/cfg_data) sets skip_bytes and
//   network_mode; write it only while no byte is in flight.
//   An accepted byte is held in the input register; its chunks are written
//   to the result buffer. Throughput: one byte per cycle while the buffer has
//   room for a pair, as each byte's hash and divisor test feed the next.
//   Reset clears all stream state and loads skip_bytes = 64, network_mode = 0.
//   When the receiver stalls, chunks collect in a four-word buffer; input is
//   held off once fewer than two free words remain, so nothing is dropped.
// ----------------------------------------------------------------------------
module rolling_hash_chunk_boundaries
  import rhcb_pkg::*;
#(
  parameter int WINDOW_LEN    = 7,
  parameter int BLOCK_DIVISOR = 320
) (
  input  wire logic              clk,
  input  wire logic              rst,
  // Configuration port.
  input  wire logic              cfg_write,
  input  wire logic [0:0]        cfg_index,
  input  wire logic [SKIP_W-1:0] cfg_data,
  // Byte input channel.
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [BYTE_W-1:0] data_byte,
  input  wire logic [POS_W-1:0]  stream_length,
  // Chunk output channel.
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [POS_W-1:0]       chunk_start,
  output logic [POS_W-1:0]       chunk_end,
  output logic                   tail_chunk,
  output logic                   chunk_empty,
  output logic                   last_of_run
);

  logic              in_q_valid;
  logic [BYTE_W-1:0] in_q_byte;
  logic [POS_W-1:0]  in_q_length;
  logic              advance;
  logic              fifo_space;
  logic              in_fire;
  result_t           res0;
  result_t           res1;
  logic [1:0]        res_count;
  logic [1:0]        push_count;
  result_t           head;

  // Input register: refills in the same cycle it drains.
  assign advance  = in_q_valid && fifo_space;
  assign in_ready = !in_q_valid || advance;
  assign in_fire  = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_q_valid <= 1'b0;
    end else if (in_fire) begin
      in_q_valid <= 1'b1;
    end else if (advance) begin
      in_q_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      in_q_byte   <= data_byte;
      in_q_length <= stream_length;
    end
  end

  rhcb_chunker #(
    .WINDOW_LEN   (WINDOW_LEN),
    .BLOCK_DIVISOR(BLOCK_DIVISOR)
  ) u_chunker (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .advance      (advance),
    .data_byte    (in_q_byte),
    .stream_length(in_q_length),
    .res0         (res0),
    .res1         (res1),
    .res_count    (res_count)
  );

  // Only a consumed byte writes its chunks.
  assign push_count = advance ? res_count : 2'd0;

  rhcb_result_fifo u_result_fifo (
    .clk       (clk),
    .rst       (rst),
    .push_count(push_count),
    .push0     (res0),
    .push1     (res1),
    .space     (fifo_space),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .head      (head)
  );

  // Output fields straight from the buffer head.
  assign chunk_start = head.chunk_start;
  assign chunk_end   = head.chunk_end;
  assign tail_chunk  = head.tail_chunk;
  assign chunk_empty = head.chunk_empty;
  assign last_of_run = head.last_of_run;

endmodule
`default_nettype wire

/* tb/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Rolling hash chunk boundary testbench
// Streams bytes into the chunker and checks every chunk word against an in-bench
// model of the rolling hash, skip window and tail logic, or typed rows' inline
// chunks. A short directed script covers reset state, length extremes, boundaries
// on the final byte, skip extremes and network mode. Random streams follow, with
// injected boundary bytes, cut-short streams and register changes.
// ----------------------------------------------------------------------------
module testbench;
  import rhcb_pkg::*;

  localparam int WINDOW_LEN    = 7;
  localparam int BLOCK_DIVISOR = 320;
  localparam int LONG_HOLD     = 200;
  localparam int SETTLE_CYCLES = 4;
  localparam int PHASE_ITEMS   = 190;

  // Mixed bytes that finish the short directed stream.
  localparam logic [7:0] MIX_BYTES [5] = '{8'h00, 8'hFF, 8'h55, 8'hAA, 8'h47};

  typedef enum logic [0:0] {
    ROW_BYTE = 1'b0,
    ROW_CFG  = 1'b1
  } row_kind_t;

  // One line of the directed script. Typed rows carry their chunks inline.
  typedef struct packed {
    row_kind_t   kind;
    cfg_reg_t    reg_sel;
    logic [31:0] data;
    logic [31:0] length;
    logic        typed;
    logic [1:0]  n_typed;
    result_t     first;
    result_t     second;
  } row_t;

  logic              clk;
  logic              rst;
  logic              cfg_write;
  logic [0:0]        cfg_index;
  logic [SKIP_W-1:0] cfg_data;
  logic              in_valid;
  logic              in_ready;
  logic [BYTE_W-1:0] data_byte;
  logic [POS_W-1:0]  stream_length;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [POS_W-1:0]  chunk_start;
  logic [POS_W-1:0]  chunk_end;
  logic              tail_chunk;
  logic              chunk_empty;
  logic              last_of_run;

  // Model of the chunker: hash window, stream position and registers.
  logic [7:0]        win_bytes [WINDOW_LEN];
  int unsigned       win_slot;
  logic [31:0]       win_sum;
  logic [31:0]       wtd_sum;
  logic [31:0]       xor_hash;
  logic [31:0]       next_pos;
  logic [31:0]       chunk_from;
  logic [SKIP_W-1:0] skip_count;
  bit                awaiting_first;
  logic [SKIP_W-1:0] cur_skip;
  bit                cur_network;

  result_t step_chunks[$];
  result_t pending_chunks[$];
  row_t    script[$];

  int mismatch_count = 0;
  int items_sent     = 0;
  int stall_pct      = 0;
  bit hold_request   = 1'b0;
  bit hold_granted   = 1'b0;
  int hold_left      = 0;

  rolling_hash_chunk_boundaries #(
    .WINDOW_LEN    (WINDOW_LEN),
    .BLOCK_DIVISOR (BLOCK_DIVISOR)
  ) DUT (
    .clk           (clk),
    .rst           (rst),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .data_byte     (data_byte),
    .stream_length (stream_length),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .chunk_start   (chunk_start),
    .chunk_end     (chunk_end),
    .tail_chunk    (tail_chunk),
    .chunk_empty   (chunk_empty),
    .last_of_run   (last_of_run)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #4_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  function automatic result_t mk_chunk(logic [31:0] s, logic [31:0] e, logic tail,
                                       logic empty, logic last);
    result_t r;
    r.chunk_start = s;
    r.chunk_end   = e;
    r.tail_chunk  = tail;
    r.chunk_empty = empty;
    r.last_of_run = last;
    return r;
  endfunction

  // Hash value that the window would give if byte c were rolled in now.
  function automatic logic [31:0] hash_with(logic [7:0] c);
    logic [31:0] s;
    logic [31:0] w;
    logic [31:0] x;
    w = wtd_sum - win_sum + 32'(WINDOW_LEN) * 32'(c);
    s = win_sum + 32'(c) - 32'(win_bytes[win_slot]);
    x = (xor_hash << HASH_SHIFT) ^ 32'(c);
    return s + w + x;
  endfunction

  function automatic bit is_boundary(logic [31:0] h);
    return (h % 32'(BLOCK_DIVISOR)) == 32'(BLOCK_DIVISOR - 1);
  endfunction

  // Finds a byte that closes a chunk from the current window, if one exists.
  function automatic logic [8:0] boundary_byte();
    logic [7:0] c;
    c = 8'($urandom);
    for (int i = 0; i < 256; i++) begin
      if (is_boundary(hash_with(c))) return {1'b1, c};
      c = c + 8'd1;
    end
    return 9'd0;
  endfunction

  task automatic clear_stream();
    foreach (win_bytes[k]) win_bytes[k] = 8'd0;
    win_slot       = 0;
    win_sum        = '0;
    wtd_sum        = '0;
    xor_hash       = '0;
    next_pos       = '0;
    chunk_from     = '0;
    skip_count     = '0;
    awaiting_first = 1'b1;
  endtask

  task automatic roll_in(logic [7:0] c);
    logic [31:0] s;
    s        = win_sum + 32'(c) - 32'(win_bytes[win_slot]);
    wtd_sum  = wtd_sum - win_sum + 32'(WINDOW_LEN) * 32'(c);
    win_sum  = s;
    xor_hash = (xor_hash << HASH_SHIFT) ^ 32'(c);
    win_bytes[win_slot] = c;
    win_slot = (win_slot + 1) % WINDOW_LEN;
  endtask

  // Chunks caused by one byte go to step_chunks; the model state advances.
  task automatic predict_chunks(logic [7:0] c, logic [31:0] len);
    logic [32:0] len_eff;
    logic [31:0] p;
    logic [31:0] h;
    bit          final_byte;
    len_eff    = (len == 32'd0) ? 33'd1 : {1'b0, len};
    p          = next_pos;
    final_byte = ({1'b0, p} + 33'd1) >= len_eff;
    step_chunks.delete();
    if (skip_count != '0) begin
      skip_count = skip_count - SKIP_W'(1);
    end else begin
      h = hash_with(c);
      roll_in(c);
      if (is_boundary(h)) begin
        if (cur_network && awaiting_first) begin
          awaiting_first = 1'b0;
        end else begin
          step_chunks.push_back(mk_chunk(chunk_from, p, 1'b0, chunk_from > p, 1'b0));
        end
        chunk_from = p + 32'd1;
        if (({1'b0, p} + 33'(cur_skip)) < len_eff) skip_count = cur_skip;
      end
    end
    if (final_byte) begin
      if (!cur_network) begin
        step_chunks.push_back(mk_chunk(chunk_from, len_eff[31:0] - 32'd1, 1'b1,
                                       chunk_from > (len_eff[31:0] - 32'd1), 1'b0));
      end
      clear_stream();
    end else begin
      next_pos = p + 32'd1;
    end
    if (step_chunks.size() > 0) step_chunks[step_chunks.size() - 1].last_of_run = 1'b1;
  endtask

  // Offers one byte word, waits for it to be taken, then books its chunks.
  // A negative typed_n means the model supplies the chunks.
  task automatic push_byte(logic [7:0] c, logic [31:0] len, int typed_n,
                           result_t t0, result_t t1);
    in_valid      <= 1'b1;
    data_byte     <= c;
    stream_length <= len;
    do @(posedge clk); while (!in_ready);
    predict_chunks(c, len);
    if (typed_n < 0) begin
      foreach (step_chunks[k]) pending_chunks.push_back(step_chunks[k]);
    end else begin
      if (typed_n > 0) pending_chunks.push_back(t0);
      if (typed_n > 1) pending_chunks.push_back(t1);
    end
    items_sent++;
  endtask

  task automatic idle_sender(int pct);
    int n;
    n = 0;
    while ($urandom_range(99) < pct) n++;
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // Stops sending and waits until every booked chunk has come out.
  task automatic drain();
    in_valid <= 1'b0;
    while (pending_chunks.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(cfg_reg_t sel, logic [SKIP_W-1:0] value);
    cfg_write <= 1'b1;
    cfg_index <= sel;
    cfg_data  <= value;
    @(posedge clk);
    if (sel == REG_SKIP_BYTES) cur_skip = value;
    else cur_network = value[0];
  endtask

  task automatic reconfigure();
    logic [SKIP_W-1:0] skip;
    case ($urandom_range(5))
      0:       skip = '0;
      1:       skip = '1;
      2:       skip = SKIP_W'($urandom_range(1, 8));
      3:       skip = SKIP_W'($urandom_range(9, 40));
      4:       skip = SKIP_W'(64);
      default: skip = SKIP_W'($urandom);
    endcase
    drain();
    write_reg(REG_SKIP_BYTES, skip);
    write_reg(REG_NETWORK_MODE, SKIP_W'($urandom_range(99) < 30));
    cfg_write <= 1'b0;
  endtask

  // One random stream: mostly short well-formed ones, some cut short by an
  // inconsistent length, with boundary bytes planted now and then.
  task automatic run_stream(int send_pct);
    int          r;
    int          n_bytes;
    bit          cut;
    logic [31:0] len;
    logic [31:0] len_field;
    logic [7:0]  c;
    logic [8:0]  pick;
    r = $urandom_range(99);
    if (r < 8) begin
      len     = (r < 4) ? 32'hFFFF_FFFF : 32'($urandom);
      cut     = 1'b1;
      n_bytes = $urandom_range(1, 31);
    end else begin
      len     = (r < 20) ? 32'($urandom_range(25, 300)) : 32'($urandom_range(1, 24));
      cut     = $urandom_range(99) < 8;
      n_bytes = cut ? $urandom_range(1, int'(len)) : int'(len);
    end
    for (int k = 0; k < n_bytes; k++) begin
      c = 8'($urandom);
      if ($urandom_range(99) < 10) c = ($urandom_range(1) != 0) ? 8'hFF : 8'h00;
      if (skip_count == '0 && $urandom_range(99) < 15) begin
        pick = boundary_byte();
        if (pick[8]) c = pick[7:0];
      end
      len_field = (cut && k == n_bytes - 1) ? 32'($urandom_range(0, k + 1)) : len;
      push_byte(c, len_field, -1, '0, '0);
      idle_sender(send_pct);
    end
  endtask

  task automatic add_row(row_kind_t kind, cfg_reg_t sel, logic [31:0] data,
                         logic [31:0] len, int typed, int n,
                         result_t r0, result_t r1);
    row_t row;
    row.kind    = kind;
    row.reg_sel = sel;
    row.data    = data;
    row.length  = len;
    row.typed   = (typed != 0);
    row.n_typed = 2'(n);
    row.first   = r0;
    row.second  = r1;
    script.push_back(row);
  endtask

  // Receiver: random stalls, plus one long hold-off on request.
  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_request != hold_granted) begin
      hold_granted <= hold_request;
      hold_left    <= LONG_HOLD;
      out_ready    <= 1'b0;
    end else begin
      out_ready <= $urandom_range(99) >= stall_pct;
    end
  end

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      mismatch_count++;
      $display("%0t: %s mismatch: expected %0h, got %0h", $time, name, want, got);
    end
  endtask

  // Each chunk word taken from the block is matched against the oldest booked one.
  always @(posedge clk) begin
    result_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_chunks.size() == 0) begin
        mismatch_count++;
        $display("%0t: unexpected chunk word: expected none, got start %0h end %0h",
                 $time, chunk_start, chunk_end);
      end else begin
        want = pending_chunks.pop_front();
        check_field("chunk_start", want.chunk_start, chunk_start);
        check_field("chunk_end", want.chunk_end, chunk_end);
        check_field("tail_chunk", 32'(want.tail_chunk), 32'(tail_chunk));
        check_field("chunk_empty", 32'(want.chunk_empty), 32'(chunk_empty));
        check_field("last_of_run", 32'(want.last_of_run), 32'(last_of_run));
      end
    end
  end

  initial begin
    result_t no_chunk;
    result_t open_chunk;
    no_chunk   = '0;
    open_chunk = mk_chunk(32'd0, 32'd0, 1'b0, 1'b0, 1'b1);

    rst           = 1'b1;
    cfg_write     = 1'b0;
    cfg_index     = REG_SKIP_BYTES;
    cfg_data      = '0;
    in_valid      = 1'b0;
    data_byte     = '0;
    stream_length = 32'd1;
    cur_skip      = SKIP_W'(64);
    cur_network   = 1'b0;
    clear_stream();

    // Directed script. Byte 0x47 closes a chunk from a fresh window.
    add_row(ROW_BYTE, REG_SKIP_BYTES, 32'h00, 32'd1, 1, 1,
            mk_chunk(32'd0, 32'd0, 1'b1, 1'b0, 1'b1), no_chunk);
    add_row(ROW_BYTE, REG_SKIP_BYTES, 32'h47, 32'd1, 1, 2,
            mk_chunk(32'd0, 32'd0, 1'b0, 1'b0, 1'b0),
            mk_chunk(32'd1, 32'd0, 1'b1, 1'b1, 1'b1));
    add_row(ROW_BYTE, REG_SKIP_BYTES, 32'hFF, 32'd0, 1, 1,
            mk_chunk(32'd0, 32'd0, 1'b1, 1'b0, 1'b1), no_chunk);
    add_row(ROW_BYTE, REG_SKIP_BYTES, 32'hFF, 32'hFFFF_FFFF, 1, 0, no_chunk, no_chunk);
    add_row(ROW_BYTE, REG_SKIP_BYTES, 32'h80, 32'hFFFF_FFFF, 0, 0, no_chunk, no_chunk);
    // Length below the position ends the stream early.
    add_row(ROW_BYTE, REG_SKIP_BYTES, 32'h01, 32'd2, 0, 0, no_chunk, no_chunk);
    add_row(ROW_BYTE, REG_SKIP_BYTES, 32'h47, 32'd6, 1, 1, open_chunk, no_chunk);
    for (int k = 0; k < 5; k++)
      add_row(ROW_BYTE, REG_SKIP_BYTES, {24'd0, MIX_BYTES[k]},
              32'd6, 0, 0, no_chunk, no_chunk);
    // A short skip window after a boundary.
    add_row(ROW_CFG, REG_SKIP_BYTES, 32'd3, 32'd0, 0, 0, no_chunk, no_chunk);
    add_row(ROW_BYTE, REG_SKIP_BYTES, 32'h47, 32'd8, 1, 1, open_chunk, no_chunk);
    for (int k = 0; k < 7; k++)
      add_row(ROW_BYTE, REG_SKIP_BYTES, 32'(8'hFF - 8'(k * 37)), 32'd8, 0, 0,
              no_chunk, no_chunk);
    add_row(ROW_CFG, REG_SKIP_BYTES, 32'd0, 32'd0, 0, 0, no_chunk, no_chunk);
    add_row(ROW_BYTE, REG_SKIP_BYTES, 32'h47, 32'd2, 1, 1, open_chunk, no_chunk);
    add_row(ROW_BYTE, REG_SKIP_BYTES, 32'h47, 32'd2, 0, 0, no_chunk, no_chunk);
    // Longest skip, then the stream is cut inside it.
    add_row(ROW_CFG, REG_SKIP_BYTES, 32'hFFF, 32'd0, 0, 0, no_chunk, no_chunk);
    add_row(ROW_BYTE, REG_SKIP_BYTES, 32'h47, 32'd5000, 1, 1, open_chunk, no_chunk);
    add_row(ROW_BYTE, REG_SKIP_BYTES, 32'h33, 32'd5000, 0, 0, no_chunk, no_chunk);
    add_row(ROW_BYTE, REG_SKIP_BYTES, 32'h33, 32'd1, 0, 0, no_chunk, no_chunk);
    // Network mode: the first boundary only opens chunking, and no tail.
    add_row(ROW_CFG, REG_NETWORK_MODE, 32'd1, 32'd0, 0, 0, no_chunk, no_chunk);
    add_row(ROW_BYTE, REG_SKIP_BYTES, 32'h47, 32'd1, 1, 0, no_chunk, no_chunk);
    add_row(ROW_BYTE, REG_SKIP_BYTES, 32'h47, 32'd3, 1, 0, no_chunk, no_chunk);
    add_row(ROW_BYTE, REG_SKIP_BYTES, 32'h47, 32'd3, 0, 0, no_chunk, no_chunk);
    add_row(ROW_BYTE, REG_SKIP_BYTES, 32'h47, 32'd3, 0, 0, no_chunk, no_chunk);
    add_row(ROW_CFG, REG_NETWORK_MODE, 32'd0, 32'd0, 0, 0, no_chunk, no_chunk);
    add_row(ROW_CFG, REG_SKIP_BYTES, 32'd64, 32'd0, 0, 0, no_chunk, no_chunk);

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    foreach (script[i]) begin
      if (script[i].kind == ROW_CFG) begin
        drain();
        write_reg(script[i].reg_sel, script[i].data[SKIP_W-1:0]);
        cfg_write <= 1'b0;
      end else begin
        push_byte(script[i].data[7:0], script[i].length,
                  script[i].typed ? int'(script[i].n_typed) : -1,
                  script[i].first, script[i].second);
      end
    end

    // Random streams in four idling phases: none, sender, receiver, both.
    for (int phase = 0; phase < 4; phase++) begin
      int send_pct;
      int target;
      send_pct  = (phase == 1) ? 74 : (phase == 3) ? 6 : 0;
      stall_pct = (phase == 2) ? 74 : (phase == 3) ? 6 : 0;
      target    = items_sent + PHASE_ITEMS;
      if (phase == 0 || phase == 3) hold_request = ~hold_request;
      while (items_sent < target) begin
        if ($urandom_range(99) < 20) reconfigure();
        run_stream(send_pct);
      end
    end

    drain();
    repeat (10) @(posedge clk);
    if (mismatch_count == 0 && pending_chunks.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
